FILE: rtl/hfba_pkg.sv
// ----------------------------------------------------------------------------
// hfba_pkg
// Shared types, codes and helpers of the half-fit block allocator.
// ----------------------------------------------------------------------------
package hfba_pkg;

  localparam int IDX_W       = 10;
  localparam int DEPTH       = 1024;
  localparam int NUM_BUCKETS = 11;
  localparam int UNIT_BYTES  = 32;

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  typedef enum logic [1:0] {
    STATUS_OK,
    STATUS_BAD_SIZE,
    STATUS_NO_FIT,
    STATUS_NOT_ALLOC
  } status_t;

  // header word without the physical prev field (kept in its own memory)
  typedef struct packed {
    logic [IDX_W-1:0] next;
    logic [IDX_W-1:0] size;   // 0 means 1024 units
    logic             alloc;
  } hdr_rest_t;

  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] idx;
  } head_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CLEAR,
    OP_LATCH,
    OP_ALOOK,
    OP_AHDR,
    OP_ASPLIT,
    OP_FCHK,
    OP_FP,
    OP_FRN,
    OP_FN,
    OP_FCLRX,
    OP_FHDR,
    OP_FAFTER,
    OP_ADD2,
    OP_LOAD_OUT
  } dp_op_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ALOOK,
    ST_AHDR,
    ST_ASPLIT,
    ST_FCHK,
    ST_FP,
    ST_FRN,
    ST_FN,
    ST_FCLRX,
    ST_FHDR,
    ST_FAFTER,
    ST_ADD2,
    ST_DONE
  } ctl_state_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic fail;
    logic exact;
    logic clr_last;
  } dp_stat_t;

  // ceil(log2(units)), units in 1..1024
  function automatic logic [3:0] bucket_of(input logic [10:0] units);
    logic [10:0] n;
    logic [3:0]  k;
    n = (units == 11'd0) ? 11'd0 : units - 11'd1;
    k = '0;
    for (int i = 0; i < 11; i++) begin
      if (n[i]) k = 4'(i + 1);
    end
    return k;
  endfunction

  function automatic logic [10:0] units_of(input logic [IDX_W-1:0] s);
    return (s == '0) ? 11'd1024 : {1'b0, s};
  endfunction

endpackage

FILE: rtl/hfba_req_if.sv
// ----------------------------------------------------------------------------
// hfba_req_if
// Request channel: allocate or free item with valid/ready handshake.
// ----------------------------------------------------------------------------
interface hfba_req_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [15:0] size_bytes;
  logic [9:0]  block_index;

  modport source (output valid, action, size_bytes, block_index, input ready);
  modport sink   (input valid, action, size_bytes, block_index, output ready);
endinterface

FILE: rtl/hfba_rsp_if.sv
// ----------------------------------------------------------------------------
// hfba_rsp_if
// Response channel: allocated index and status with valid/ready handshake.
// ----------------------------------------------------------------------------
interface hfba_rsp_if;
  logic       valid;
  logic       ready;
  logic [9:0] result_index;
  logic [1:0] status;

  modport source (output valid, result_index, status, input ready);
  modport sink   (input valid, result_index, status, output ready);
endinterface

FILE: rtl/hfba_datapath.sv
// ----------------------------------------------------------------------------
// hfba_datapath
// Header and bucket-link memories, bucket heads, and per-step update logic.
// ----------------------------------------------------------------------------
module hfba_datapath #(
  parameter int MEMORY_BYTES = 32768
) (
  input  logic               clk,
  input  logic               rst,
  input  hfba_pkg::dp_cmd_t  cmd,
  output hfba_pkg::dp_stat_t stat,
  input  logic [15:0]        size_bytes,
  input  logic [9:0]         block_index,
  output logic [9:0]         result_index,
  output logic [1:0]         status
);

  localparam int          NUM_UNITS  = MEMORY_BYTES / hfba_pkg::UNIT_BYTES;
  localparam int          TOP_BUCKET = $clog2(NUM_UNITS);
  localparam logic [3:0]  TOP_K      = 4'(TOP_BUCKET);
  localparam logic [15:0] MEM_LIMIT  = 16'(MEMORY_BYTES);
  localparam logic [9:0]  INIT_SIZE  = 10'(NUM_UNITS);

  // memories
  logic [9:0]          prev_mem  [hfba_pkg::DEPTH];
  hfba_pkg::hdr_rest_t rest_mem  [hfba_pkg::DEPTH];
  logic [9:0]          lprev_mem [hfba_pkg::DEPTH];
  logic [9:0]          lnext_mem [hfba_pkg::DEPTH];

  logic [9:0]          prev_rd, lp_rd, ln_rd;
  hfba_pkg::hdr_rest_t rest_rd;
  logic [9:0]          rd_addr;

  logic                prev_we, rest_we, lp_we, ln_we;
  logic [9:0]          prev_wa, rest_wa, lp_wa, ln_wa;
  logic [9:0]          prev_wd, lp_wd, ln_wd;
  hfba_pkg::hdr_rest_t rest_wd;

  hfba_pkg::head_t     heads [hfba_pkg::NUM_BUCKETS];
  logic                head_we;
  logic [3:0]          head_k;
  hfba_pkg::head_t     head_wd;

  // working registers
  logic [15:0] size_r;
  logic [9:0]  x_r, b_r, e_r, bn_r, p_r, n_r, start_r, mprev_r, after_r, add_idx;
  logic [10:0] req_r, total_r, add_units;
  logic        has_p_r, has_after_r;
  logic [9:0]  res_index, out_index;
  hfba_pkg::status_t res_status, out_status;
  logic [9:0]  clr_cnt;

  // combinational
  logic [16:0] req_sum;
  logic [10:0] req_calc, hdr_units, split_units;
  logic [3:0]  k_req, add_k, rm_k;
  logic        invalid_size, found, fit, exact, has_p, has_n;
  logic [9:0]  b_sel, e_calc;
  logic        rm_en;
  logic [9:0]  rm_x;
  logic [10:0] rm_units;
  hfba_pkg::head_t add_head;

  assign req_sum      = {1'b0, size_r} + 17'd31;
  assign req_calc     = req_sum[15:5];
  assign invalid_size = (size_r == 16'd0) || (size_r > MEM_LIMIT);
  assign k_req        = hfba_pkg::bucket_of(req_calc);
  assign hdr_units    = hfba_pkg::units_of(rest_rd.size);
  assign fit          = (req_r <= hdr_units);
  assign exact        = (req_r == hdr_units);
  assign split_units  = hdr_units - req_r;
  assign e_calc       = b_r + req_r[9:0];
  assign has_p        = (p_r != x_r) && !rest_rd.alloc;
  assign has_n        = (n_r != x_r) && !rest_rd.alloc;
  assign add_k        = hfba_pkg::bucket_of(add_units);
  assign add_head     = heads[add_k];
  assign rm_k         = hfba_pkg::bucket_of(rm_units);

  // first non-empty bucket above the request's; top bucket checked directly
  always_comb begin
    found = 1'b0;
    b_sel = '0;
    if (k_req >= TOP_K) begin
      found = heads[TOP_BUCKET].valid;
      b_sel = heads[TOP_BUCKET].idx;
    end else begin
      for (int j = 0; j < hfba_pkg::NUM_BUCKETS; j++) begin
        if (!found && (4'(j) > k_req) && (j <= TOP_BUCKET) && heads[j].valid) begin
          found = 1'b1;
          b_sel = heads[j].idx;
        end
      end
    end
  end

  always_comb begin
    stat.clr_last = (clr_cnt == 10'(hfba_pkg::DEPTH - 1));
    stat.exact    = exact;
    unique case (cmd.op)
      hfba_pkg::OP_ALOOK: stat.fail = invalid_size || !found;
      hfba_pkg::OP_AHDR:  stat.fail = !fit;
      hfba_pkg::OP_FCHK:  stat.fail = !rest_rd.alloc;
      default:            stat.fail = 1'b0;
    endcase
  end

  // memory write and read control
  always_comb begin
    rd_addr  = x_r;
    prev_we  = 1'b0; prev_wa = x_r; prev_wd = '0;
    rest_we  = 1'b0; rest_wa = x_r; rest_wd = '0;
    lp_we    = 1'b0; lp_wa   = x_r; lp_wd   = '0;
    ln_we    = 1'b0; ln_wa   = x_r; ln_wd   = '0;
    head_we  = 1'b0; head_k  = add_k; head_wd = '0;
    rm_en    = 1'b0; rm_x    = b_r; rm_units = hdr_units;
    unique case (cmd.op)
      hfba_pkg::OP_CLEAR: begin
        prev_we = 1'b1; prev_wa = clr_cnt;
        rest_we = 1'b1; rest_wa = clr_cnt;
        lp_we   = 1'b1; lp_wa   = clr_cnt;
        ln_we   = 1'b1; ln_wa   = clr_cnt;
        if (clr_cnt == '0) rest_wd = '{next: '0, size: INIT_SIZE, alloc: 1'b0};
      end
      hfba_pkg::OP_LATCH: rd_addr = block_index;
      hfba_pkg::OP_ALOOK: rd_addr = b_sel;
      hfba_pkg::OP_AHDR: begin
        if (fit) begin
          rm_en = 1'b1;
          rm_x  = b_r;
          rest_we = 1'b1;
          if (exact) begin
            rest_wa = b_r;
            rest_wd = '{next: rest_rd.next, size: rest_rd.size, alloc: 1'b1};
          end else begin
            rest_wa = e_calc;
            rest_wd = '{next: (rest_rd.next == b_r) ? e_calc : rest_rd.next,
                        size: split_units[9:0], alloc: 1'b0};
            prev_we = 1'b1; prev_wa = e_calc; prev_wd = b_r;
          end
        end
      end
      hfba_pkg::OP_ASPLIT: begin
        rest_we = 1'b1; rest_wa = b_r;
        rest_wd = '{next: e_r, size: req_r[9:0], alloc: 1'b1};
        if (bn_r != b_r) begin
          prev_we = 1'b1; prev_wa = bn_r; prev_wd = e_r;
        end
        lp_we = add_head.valid; lp_wa = add_head.idx; lp_wd = add_idx;
        ln_we = 1'b1; ln_wa = add_idx; ln_wd = add_head.valid ? add_head.idx : add_idx;
      end
      hfba_pkg::OP_FCHK: rd_addr = prev_rd;
      hfba_pkg::OP_FP: begin
        if (has_p) begin
          rm_en = 1'b1;
          rm_x  = p_r;
        end
      end
      hfba_pkg::OP_FRN: rd_addr = n_r;
      hfba_pkg::OP_FN: begin
        if (has_n) begin
          rm_en = 1'b1;
          rm_x  = n_r;
          rest_we = 1'b1; rest_wa = n_r;
          prev_we = 1'b1; prev_wa = n_r;
        end
      end
      hfba_pkg::OP_FCLRX: begin
        rest_we = has_p_r;
        prev_we = has_p_r;
      end
      hfba_pkg::OP_FHDR: begin
        rest_we = 1'b1; rest_wa = start_r;
        rest_wd = '{next: has_after_r ? after_r : start_r, size: total_r[9:0],
                    alloc: 1'b0};
        prev_we = 1'b1; prev_wa = start_r; prev_wd = mprev_r;
      end
      hfba_pkg::OP_FAFTER: begin
        prev_we = has_after_r; prev_wa = after_r; prev_wd = start_r;
        lp_we = add_head.valid; lp_wa = add_head.idx; lp_wd = add_idx;
        ln_we = 1'b1; ln_wa = add_idx; ln_wd = add_head.valid ? add_head.idx : add_idx;
      end
      hfba_pkg::OP_ADD2: begin
        lp_we   = 1'b1; lp_wa = add_idx; lp_wd = add_idx;
        head_we = 1'b1; head_k = add_k;
        head_wd = '{valid: 1'b1, idx: add_idx};
      end
      default: ;
    endcase

    // direct unlink from a bucket list; links of rm_x are in lp_rd / ln_rd
    if (rm_en) begin
      head_k = rm_k;
      if (lp_rd == rm_x && ln_rd == rm_x) begin
        head_we = 1'b1; head_wd = '0;
      end else if (lp_rd == rm_x) begin
        head_we = 1'b1; head_wd = '{valid: 1'b1, idx: ln_rd};
        lp_we = 1'b1; lp_wa = ln_rd; lp_wd = ln_rd;
      end else if (ln_rd == rm_x) begin
        ln_we = 1'b1; ln_wa = lp_rd; ln_wd = lp_rd;
      end else begin
        ln_we = 1'b1; ln_wa = lp_rd; ln_wd = ln_rd;
        lp_we = 1'b1; lp_wa = ln_rd; lp_wd = lp_rd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (prev_we) prev_mem[prev_wa] <= prev_wd;
    if (rest_we) rest_mem[rest_wa] <= rest_wd;
    if (lp_we)   lprev_mem[lp_wa]  <= lp_wd;
    if (ln_we)   lnext_mem[ln_wa]  <= ln_wd;
    prev_rd <= prev_mem[rd_addr];
    rest_rd <= rest_mem[rd_addr];
    lp_rd   <= lprev_mem[rd_addr];
    ln_rd   <= lnext_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < hfba_pkg::NUM_BUCKETS; i++)
        heads[i] <= '{valid: (i == TOP_BUCKET), idx: '0};
      clr_cnt    <= '0;
      out_index  <= '0;
      out_status <= hfba_pkg::STATUS_OK;
    end else begin
      if (head_we) heads[head_k] <= head_wd;
      if (cmd.op == hfba_pkg::OP_CLEAR) clr_cnt <= clr_cnt + 10'd1;
      if (cmd.op == hfba_pkg::OP_LOAD_OUT) begin
        out_index  <= res_index;
        out_status <= res_status;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      hfba_pkg::OP_LATCH: begin
        size_r     <= size_bytes;
        x_r        <= block_index;
        res_index  <= '0;
        res_status <= hfba_pkg::STATUS_OK;
      end
      hfba_pkg::OP_ALOOK: begin
        req_r <= req_calc;
        b_r   <= b_sel;
        if (invalid_size)  res_status <= hfba_pkg::STATUS_BAD_SIZE;
        else if (!found)   res_status <= hfba_pkg::STATUS_NO_FIT;
      end
      hfba_pkg::OP_AHDR: begin
        if (!fit) begin
          res_status <= hfba_pkg::STATUS_NO_FIT;
        end else begin
          res_index <= b_r;
          e_r       <= e_calc;
          bn_r      <= rest_rd.next;
          add_idx   <= e_calc;
          add_units <= split_units;
        end
      end
      hfba_pkg::OP_FCHK: begin
        if (!rest_rd.alloc) res_status <= hfba_pkg::STATUS_NOT_ALLOC;
        total_r <= hdr_units;
        p_r     <= prev_rd;
        n_r     <= rest_rd.next;
      end
      hfba_pkg::OP_FP: begin
        has_p_r <= has_p;
        if (has_p) begin
          total_r <= total_r + hdr_units;
          start_r <= p_r;
          mprev_r <= prev_rd;
        end else begin
          start_r <= x_r;
          mprev_r <= p_r;
        end
      end
      hfba_pkg::OP_FN: begin
        if (has_n) begin
          total_r     <= total_r + hdr_units;
          has_after_r <= (rest_rd.next != n_r);
          after_r     <= rest_rd.next;
        end else begin
          has_after_r <= (n_r != x_r);
          after_r     <= n_r;
        end
      end
      hfba_pkg::OP_FHDR: begin
        add_idx   <= start_r;
        add_units <= total_r;
      end
      default: ;
    endcase
  end

  assign result_index = out_index;
  assign status       = out_status;

  a_add_sets_head: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == hfba_pkg::OP_ADD2) |=> heads[$past(add_k)].valid)
    else $error("bucket head not valid after insert");

  a_fail_index_zero: assert property (@(posedge clk) disable iff (rst)
    (out_status != hfba_pkg::STATUS_OK) |-> (out_index == '0))
    else $error("nonzero index on failed item");

endmodule

FILE: rtl/hfba_ctrl.sv
// ----------------------------------------------------------------------------
// hfba_ctrl
// Sequencer: clear pass, request handshake, step order, output register.
// ----------------------------------------------------------------------------
module hfba_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  input  logic               req_action,
  output logic               req_ready,
  input  logic               rsp_ready,
  output logic               rsp_valid,
  output hfba_pkg::dp_cmd_t  cmd,
  input  hfba_pkg::dp_stat_t stat
);

  hfba_pkg::ctl_state_t state, state_next;
  logic out_free;

  assign out_free  = !rsp_valid || rsp_ready;
  assign req_ready = (state == hfba_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= hfba_pkg::ST_CLEAR;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.op == hfba_pkg::OP_LOAD_OUT) rsp_valid <= 1'b1;
      else if (rsp_ready)                  rsp_valid <= 1'b0;
    end
  end

  always_comb begin
    state_next = state;
    cmd.op     = hfba_pkg::OP_NONE;
    unique case (state)
      hfba_pkg::ST_CLEAR: begin
        cmd.op = hfba_pkg::OP_CLEAR;
        if (stat.clr_last) state_next = hfba_pkg::ST_IDLE;
      end
      hfba_pkg::ST_IDLE: begin
        if (req_valid) begin
          cmd.op     = hfba_pkg::OP_LATCH;
          state_next = (req_action == hfba_pkg::ACT_FREE) ? hfba_pkg::ST_FCHK
                                                          : hfba_pkg::ST_ALOOK;
        end
      end
      hfba_pkg::ST_ALOOK: begin
        cmd.op     = hfba_pkg::OP_ALOOK;
        state_next = stat.fail ? hfba_pkg::ST_DONE : hfba_pkg::ST_AHDR;
      end
      hfba_pkg::ST_AHDR: begin
        cmd.op     = hfba_pkg::OP_AHDR;
        state_next = (stat.fail || stat.exact) ? hfba_pkg::ST_DONE : hfba_pkg::ST_ASPLIT;
      end
      hfba_pkg::ST_ASPLIT: begin
        cmd.op     = hfba_pkg::OP_ASPLIT;
        state_next = hfba_pkg::ST_ADD2;
      end
      hfba_pkg::ST_FCHK: begin
        cmd.op     = hfba_pkg::OP_FCHK;
        state_next = stat.fail ? hfba_pkg::ST_DONE : hfba_pkg::ST_FP;
      end
      hfba_pkg::ST_FP: begin
        cmd.op     = hfba_pkg::OP_FP;
        state_next = hfba_pkg::ST_FRN;
      end
      hfba_pkg::ST_FRN: begin
        cmd.op     = hfba_pkg::OP_FRN;
        state_next = hfba_pkg::ST_FN;
      end
      hfba_pkg::ST_FN: begin
        cmd.op     = hfba_pkg::OP_FN;
        state_next = hfba_pkg::ST_FCLRX;
      end
      hfba_pkg::ST_FCLRX: begin
        cmd.op     = hfba_pkg::OP_FCLRX;
        state_next = hfba_pkg::ST_FHDR;
      end
      hfba_pkg::ST_FHDR: begin
        cmd.op     = hfba_pkg::OP_FHDR;
        state_next = hfba_pkg::ST_FAFTER;
      end
      hfba_pkg::ST_FAFTER: begin
        cmd.op     = hfba_pkg::OP_FAFTER;
        state_next = hfba_pkg::ST_ADD2;
      end
      hfba_pkg::ST_ADD2: begin
        cmd.op     = hfba_pkg::OP_ADD2;
        state_next = hfba_pkg::ST_DONE;
      end
      hfba_pkg::ST_DONE: begin
        if (out_free) begin
          cmd.op     = hfba_pkg::OP_LOAD_OUT;
          state_next = hfba_pkg::ST_IDLE;
        end
      end
      default: state_next = hfba_pkg::ST_CLEAR;
    endcase
  end

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    (state == hfba_pkg::ST_IDLE && req_valid) |=> (state != hfba_pkg::ST_IDLE))
    else $error("accepted item did not start");

  a_load_sets_valid: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == hfba_pkg::OP_LOAD_OUT) |=> rsp_valid)
    else $error("result loaded without valid");

  a_split_path: assert property (@(posedge clk) disable iff (rst)
    (state == hfba_pkg::ST_AHDR && !stat.fail && !stat.exact)
      |=> (state == hfba_pkg::ST_ASPLIT))
    else $error("split step skipped");

  a_no_result_in_clear: assert property (@(posedge clk) disable iff (rst)
    (state == hfba_pkg::ST_CLEAR) |-> !rsp_valid)
    else $error("result during clear pass");

endmodule

FILE: rtl/half_fit_block_allocator.sv
// Items: one item at a time; the next item is accepted only once the result is
//   registered and the sequencer is back in idle, each step reading and writing
//   the header and bucket-link memories.
// Reset: a clear pass over the header and bucket-link memories, no item accepted.
// ----------------------------------------------------------------------------
// half_fit_block_allocator
// Half-fit allocator over unit-granular memory with split and coalesce.
// ----------------------------------------------------------------------------
module half_fit_block_allocator #(
  parameter int MEMORY_BYTES = 32768
) (
  input logic         clk,
  input logic         rst,
  hfba_req_if.sink    req,
  hfba_rsp_if.source  rsp
);

  hfba_pkg::dp_cmd_t  cmd;
  hfba_pkg::dp_stat_t stat;

  hfba_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req.valid),
    .req_action (req.action),
    .req_ready  (req.ready),
    .rsp_ready  (rsp.ready),
    .rsp_valid  (rsp.valid),
    .cmd        (cmd),
    .stat       (stat)
  );

  hfba_datapath #(
    .MEMORY_BYTES (MEMORY_BYTES)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .size_bytes   (req.size_bytes),
    .block_index  (req.block_index),
    .result_index (rsp.result_index),
    .status       (rsp.status)
  );

endmodule
